// ===== design/tiht_pkg.sv =====
// ----------------------------------------------------------------------------
// tiht_pkg
// Shared types and fixed field widths of the triple intern hash table.
// ----------------------------------------------------------------------------
package tiht_pkg;

    localparam int NAME_W  = 32;
    localparam int VER_W   = 32;
    localparam int FLAG_W  = 6;
    localparam int OUT_W   = 10;

    // One interned triple, as kept in the entry store and used as probe key.
    typedef struct packed {
        logic [NAME_W-1:0] name_id;
        logic [VER_W-1:0]  version_id;
        logic [FLAG_W-1:0] relation_flags;
    } t_entry;

endpackage

// ===== design/tiht_slot_mem.sv =====
// ----------------------------------------------------------------------------
// tiht_slot_mem
// Open-addressed slot table: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tiht_slot_mem #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11,
    parameter int DATA_W = 10
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/tiht_entry_mem.sv =====
// ----------------------------------------------------------------------------
// tiht_entry_mem
// Entry store holding the triple of each interned index; registered read.
// ----------------------------------------------------------------------------
module tiht_entry_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [ADDR_W-1:0]  i_waddr,
    input  tiht_pkg::t_entry   i_wdata,
    input  logic [ADDR_W-1:0]  i_raddr,
    output tiht_pkg::t_entry   o_rdata
);

    tiht_pkg::t_entry r_mem [DEPTH];
    tiht_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/triple_intern_hash_table.sv =====
// ----------------------------------------------------------------------------
// triple_intern_hash_table
// Interns (name, version, flags) triples in a linear-probed slot table.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot table to empty, one slot a cycle, and
// holds busy high during the sweep. A request is taken when start is high
// and busy is low; busy then stays high until the result strobe (o_valid),
// which lasts one cycle and cannot be held off. Each probe reads the slot, then
// the entry of the occupied slot, both from synchronous memories with a
// registered read. A hit ends the request once the entry matches; a miss ends
// on an empty slot, or once the whole table has been probed.
module triple_intern_hash_table #(
    parameter int SLOT_COUNT     = 2048,
    parameter int ENTRY_CAPACITY = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tiht_pkg::NAME_W-1:0]   i_name_id,
    input  logic [tiht_pkg::VER_W-1:0]    i_version_id,
    input  logic [tiht_pkg::FLAG_W-1:0]   i_relation_flags,
    input  logic                          i_create,
    output logic                          o_valid,
    output logic [tiht_pkg::OUT_W-1:0]    o_entry_index,
    output logic                          o_was_found,
    output logic                          o_was_created,
    output logic                          o_table_full
);

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int IDX_W  = $clog2(ENTRY_CAPACITY);
    localparam int CNT_W  = $clog2(ENTRY_CAPACITY + 1);
    localparam int KEY_W  = $bits(tiht_pkg::t_entry);
    localparam int NCHUNK = (KEY_W + SLOT_W - 1) / SLOT_W;
    localparam int PAD_W  = NCHUNK * SLOT_W;
    localparam int OUT_W  = tiht_pkg::OUT_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SLOT,
        S_ENTRY
    } t_state;

    // XOR fold of the key to slot width, then one conditional subtract.
    function automatic logic [SLOT_W-1:0] f_hash(input tiht_pkg::t_entry k);
        logic [PAD_W-1:0]  key;
        logic [SLOT_W-1:0] fold;
        logic [SLOT_W:0]   wide;
        key  = PAD_W'(k);
        fold = '0;
        for (int c = 0; c < NCHUNK; c++) begin
            fold = fold ^ key[c*SLOT_W +: SLOT_W];
        end
        wide = {1'b0, fold};
        if (wide >= (SLOT_W+1)'(SLOT_COUNT)) begin
            wide = wide - (SLOT_W+1)'(SLOT_COUNT);
        end
        return wide[SLOT_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] f_out_idx(input logic [IDX_W-1:0] id);
        logic [IDX_W+OUT_W-1:0] tmp;
        tmp = {{OUT_W{1'b0}}, id};
        return tmp[OUT_W-1:0];
    endfunction

    t_state                  r_state, n_state;
    logic [SLOT_W-1:0]       r_probe, n_probe;
    logic [SLOT_W-1:0]       r_probes, n_probes;
    logic [CNT_W-1:0]        r_next, n_next;
    logic [IDX_W-1:0]        r_id, n_id;
    tiht_pkg::t_entry        r_key, n_key;
    logic                    r_create, n_create;
    logic                    r_valid, n_valid;
    logic [OUT_W-1:0]        r_index, n_index;
    logic                    r_found, n_found;
    logic                    r_created, n_created;
    logic                    r_full, n_full;

    logic                    slot_we;
    logic [SLOT_W-1:0]       slot_waddr;
    logic [IDX_W-1:0]        slot_wdata;
    logic [SLOT_W-1:0]       slot_raddr;
    logic [IDX_W-1:0]        slot_rdata;
    logic                    ent_we;
    logic [IDX_W-1:0]        ent_raddr;
    tiht_pkg::t_entry        ent_rdata;
    tiht_pkg::t_entry        in_key;
    logic [SLOT_W-1:0]       probe_inc;
    logic                    room;

    assign in_key    = '{name_id: i_name_id, version_id: i_version_id,
                         relation_flags: i_relation_flags};
    assign probe_inc = (r_probe == SLOT_W'(SLOT_COUNT - 1)) ? '0 : r_probe + 1'b1;
    assign room      = (r_next < CNT_W'(ENTRY_CAPACITY));

    always_comb begin
        n_state    = r_state;
        n_probe    = r_probe;
        n_probes   = r_probes;
        n_next     = r_next;
        n_id       = r_id;
        n_key      = r_key;
        n_create   = r_create;
        n_valid    = 1'b0;
        n_index    = '0;
        n_found    = 1'b0;
        n_created  = 1'b0;
        n_full     = 1'b0;
        slot_we    = 1'b0;
        slot_waddr = r_probe;
        slot_wdata = '0;
        slot_raddr = r_probe;
        ent_we     = 1'b0;
        ent_raddr  = slot_rdata;

        case (r_state)
            S_CLEAR: begin
                slot_we = 1'b1;
                n_probe = probe_inc;
                if (r_probe == SLOT_W'(SLOT_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                slot_raddr = f_hash(in_key);
                if (start) begin
                    n_key    = in_key;
                    n_create = i_create;
                    n_probe  = f_hash(in_key);
                    n_probes = '0;
                    n_state  = S_SLOT;
                end
            end
            S_SLOT: begin
                if (slot_rdata == '0) begin
                    // Empty slot ends the probe: miss
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                    if (r_create) begin
                        if (room) begin
                            slot_we    = 1'b1;
                            slot_wdata = r_next[IDX_W-1:0];
                            ent_we     = 1'b1;
                            n_index    = f_out_idx(r_next[IDX_W-1:0]);
                            n_created  = 1'b1;
                            n_next     = r_next + 1'b1;
                        end else begin
                            n_full = 1'b1;
                        end
                    end
                end else begin
                    n_id    = slot_rdata;
                    n_state = S_ENTRY;
                end
            end
            S_ENTRY: begin
                if (ent_rdata == r_key) begin
                    n_valid = 1'b1;
                    n_index = f_out_idx(r_id);
                    n_found = 1'b1;
                    n_state = S_IDLE;
                end else if (r_probes == SLOT_W'(SLOT_COUNT - 1)) begin
                    // whole table probed, no empty slot
                    n_valid = 1'b1;
                    n_full  = r_create;
                    n_state = S_IDLE;
                end else begin
                    slot_raddr = probe_inc;
                    n_probe    = probe_inc;
                    n_probes   = r_probes + 1'b1;
                    n_state    = S_SLOT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_probe <= '0;
            r_next  <= CNT_W'(1);
            r_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_probe   <= n_probe;
            r_next    <= n_next;
            r_valid   <= n_valid;
            r_probes  <= n_probes;
            r_id      <= n_id;
            r_key     <= n_key;
            r_create  <= n_create;
            r_index   <= n_index;
            r_found   <= n_found;
            r_created <= n_created;
            r_full    <= n_full;
        end
    end

    tiht_slot_mem #(
        .DEPTH  (SLOT_COUNT),
        .ADDR_W (SLOT_W),
        .DATA_W (IDX_W)
    ) u_slot_mem (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    tiht_entry_mem #(
        .DEPTH  (ENTRY_CAPACITY),
        .ADDR_W (IDX_W)
    ) u_entry_mem (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (r_next[IDX_W-1:0]),
        .i_wdata (r_key),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_entry_index = r_index;
    assign o_was_found   = r_found;
    assign o_was_created = r_created;
    assign o_table_full  = r_full;

endmodule

// ===== design/tiht_checker.sv =====
// ----------------------------------------------------------------------------
// tiht_checker
// Port-level checks of the triple intern hash table, bound to the top level.
// ----------------------------------------------------------------------------
module tiht_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_valid,
    input logic [tiht_pkg::OUT_W-1:0]  o_entry_index,
    input logic                        o_was_found,
    input logic                        o_was_created,
    input logic                        o_table_full
);

    // an accepted request keeps the block busy until its result
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after request");

    // results appear only once the block is free again, never back to back
    a_valid_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && !$past(o_valid)))
        else $error("result strobe while busy or repeated");

    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($countones({o_was_found, o_was_created, o_table_full}) <= 1))
        else $error("more than one outcome flag");

    a_index_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_was_found || o_was_created)) |-> (o_entry_index != '0))
        else $error("hit or insert with index zero");

endmodule

bind triple_intern_hash_table tiht_checker u_tiht_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_entry_index (o_entry_index),
    .o_was_found   (o_was_found),
    .o_was_created (o_was_created),
    .o_table_full  (o_table_full)
);

// ===== tb/triple_intern_hash_table_test.sv =====
// ----------------------------------------------------------------------------
// triple_intern_hash_table_test
// Self-checking bench for the triple intern table. Requests go in over
// start/busy; each expected index comes from a keyed copy of the interned
// triples, so the check does not depend on how the block hashes or probes.
// ----------------------------------------------------------------------------
module triple_intern_hash_table_test;

    localparam int SLOTS           = 2048;
    localparam int CAPACITY        = 1024;
    localparam int IDLE_LIMIT      = 20000;
    localparam int TAIL_CYCLES     = 200;
    localparam int RANDOM_REQUESTS = 100;

    typedef struct packed {
        logic [tiht_pkg::OUT_W-1:0] entry_index;
        logic                       was_found;
        logic                       was_created;
        logic                       table_full;
    } t_outcome;

    logic                          i_clk            = 1'b0;
    logic                          i_rst_n          = 1'b0;
    logic                          start            = 1'b0;
    logic [tiht_pkg::NAME_W-1:0]   i_name_id        = '0;
    logic [tiht_pkg::VER_W-1:0]    i_version_id     = '0;
    logic [tiht_pkg::FLAG_W-1:0]   i_relation_flags = '0;
    logic                          i_create         = 1'b0;
    logic                          busy;
    logic                          o_valid;
    logic [tiht_pkg::OUT_W-1:0]    o_entry_index;
    logic                          o_was_found;
    logic                          o_was_created;
    logic                          o_table_full;

    t_outcome          pending_outcomes[$];
    int unsigned       interned_index[tiht_pkg::t_entry];
    int unsigned       next_entry = 1;
    tiht_pkg::t_entry  sent_keys[$];
    int                mismatch_count = 0;
    int                idle_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    triple_intern_hash_table #(
        .SLOT_COUNT     (SLOTS),
        .ENTRY_CAPACITY (CAPACITY)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_name_id        (i_name_id),
        .i_version_id     (i_version_id),
        .i_relation_flags (i_relation_flags),
        .i_create         (i_create),
        .o_valid          (o_valid),
        .o_entry_index    (o_entry_index),
        .o_was_found      (o_was_found),
        .o_was_created    (o_was_created),
        .o_table_full     (o_table_full)
    );

    // Hit returns the stored index; a create miss appends unless the store is used up.
    function automatic t_outcome intern_predict(tiht_pkg::t_entry key, logic create);
        t_outcome    r = '0;
        int unsigned idx;
        if (interned_index.exists(key)) begin
            idx           = interned_index[key];
            r.entry_index = idx[tiht_pkg::OUT_W-1:0];
            r.was_found   = 1'b1;
        end else if (create) begin
            if (next_entry >= CAPACITY) begin
                r.table_full = 1'b1;
            end else begin
                interned_index[key] = next_entry;
                r.entry_index       = next_entry[tiht_pkg::OUT_W-1:0];
                r.was_created       = 1'b1;
                next_entry++;
            end
        end
        return r;
    endfunction

    function automatic tiht_pkg::t_entry make_key(logic [tiht_pkg::NAME_W-1:0] n,
                                                  logic [tiht_pkg::VER_W-1:0] v,
                                                  logic [tiht_pkg::FLAG_W-1:0] f);
        tiht_pkg::t_entry key;
        key.name_id        = n;
        key.version_id     = v;
        key.relation_flags = f;
        return key;
    endfunction

    // Biased toward all-zero, all-one, single-bit and single-zero-bit words.
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h1 << $urandom_range(0, 31);
            3: return ~(32'h1 << $urandom_range(0, 31));
            default: return $urandom();
        endcase
    endfunction

    function automatic tiht_pkg::t_entry fresh_key();
        return make_key(rand_word(), rand_word(), tiht_pkg::FLAG_W'($urandom_range(0, 63)));
    endfunction

    // Near miss: one field of a known triple changed by a single bit.
    function automatic tiht_pkg::t_entry mutate_key(tiht_pkg::t_entry key);
        case ($urandom_range(0, 2))
            0: key.name_id ^= 32'h1 << $urandom_range(0, 31);
            1: key.version_id ^= 32'h1 << $urandom_range(0, 31);
            default: key.relation_flags ^= 6'h1 << $urandom_range(0, 5);
        endcase
        return key;
    endfunction

    function automatic tiht_pkg::t_entry known_key();
        return sent_keys[$urandom_range(0, sent_keys.size() - 1)];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    // Called on a clock edge; returns on the edge that takes the request.
    // start is left high so a back-to-back request needs no second assignment.
    task automatic issue_request(input tiht_pkg::t_entry key, input logic create);
        start            <= 1'b1;
        i_name_id        <= key.name_id;
        i_version_id     <= key.version_id;
        i_relation_flags <= key.relation_flags;
        i_create         <= create;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_outcomes.push_back(intern_predict(key, create));
        sent_keys.push_back(key);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // start is already low when nothing is pending
    task automatic wait_drained();
        if (pending_outcomes.size() != 0) begin
            start <= 1'b0;
            while (pending_outcomes.size() != 0) @(posedge i_clk);
        end
    endtask

    task automatic test_directed_cases();
        tiht_pkg::t_entry zero;
        tiht_pkg::t_entry ones;
        zero = make_key(32'h0, 32'h0, 6'h00);
        ones = make_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F);
        issue_request(zero, 1'b0);                              // lookup on empty table
        issue_request(zero, 1'b1);
        issue_request(ones, 1'b1);
        issue_request(zero, 1'b0);
        issue_request(ones, 1'b1);                              // hit with create set
        issue_request(make_key(32'h1, 32'h0, 6'h00), 1'b0);
        issue_request(make_key(32'hFFFF_FFFF, 32'h7FFF_FFFF, 6'h3F), 1'b0);
        issue_request(make_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h00), 1'b0);
        idle_sender(3);
        issue_request(make_key(32'h0, 32'h0, 6'h20), 1'b1);
        issue_request(make_key(32'h8000_0000, 32'h0, 6'h00), 1'b1);
        issue_request(make_key(32'hFFFF_FFFF, 32'h0, 6'h3F), 1'b1);
        idle_sender(1);
        issue_request(make_key(32'h0, 32'h0, 6'h20), 1'b0);
        issue_request(make_key(32'h8000_0000, 32'h0, 6'h00), 1'b1);
        issue_request(make_key(32'hFFFF_FFFF, 32'h0, 6'h3F), 1'b0);
        issue_request(make_key(32'h0, 32'hFFFF_FFFF, 6'h01), 1'b1);
        issue_request(make_key(32'h0, 32'hFFFF_FFFF, 6'h01), 1'b0);
        issue_request(ones, 1'b0);
        issue_request(zero, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_mix();
        int               burst = 0;
        int               pick;
        tiht_pkg::t_entry key;
        logic             create;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                key    = fresh_key();
                create = ($urandom_range(0, 9) != 0);
            end else if (pick < 60) begin
                key    = known_key();
                create = 1'($urandom_range(0, 1));
            end else if (pick < 80) begin
                key    = mutate_key(known_key());
                create = 1'($urandom_range(0, 1));
            end else begin
                key    = fresh_key();
                create = 1'b0;
            end
            issue_request(key, create);
            if (n == RANDOM_REQUESTS / 2) begin
                wait_drained();
            end else if (burst > 0) begin
                burst--;
            end else if ($urandom_range(0, 49) == 0) begin
                burst = $urandom_range(20, 40);
            end else begin
                idle_sender(pick_gap());
            end
        end
        wait_drained();
    endtask

    task automatic test_fill_to_capacity();
        while (next_entry < CAPACITY) begin
            issue_request(fresh_key(), 1'b1);
            idle_sender(pick_gap());
        end
        // store used up: new triples are refused, known ones still hit
        for (int n = 0; n < 24; n++) begin
            case (n % 3)
                0: issue_request(fresh_key(), 1'b1);
                1: issue_request(known_key(), 1'($urandom_range(0, 1)));
                default: issue_request(fresh_key(), 1'b0);
            endcase
            idle_sender(pick_gap());
        end
        wait_drained();
    endtask

    always @(posedge i_clk) begin : check_results
        t_outcome want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_outcomes.size() == 0) begin
                $error("unexpected result: entry_index %0d", o_entry_index);
                mismatch_count++;
            end else begin
                want = pending_outcomes.pop_front();
                if (o_entry_index !== want.entry_index) begin
                    $error("entry_index: expected %0d, got %0d", want.entry_index, o_entry_index);
                    mismatch_count++;
                end
                if (o_was_found !== want.was_found) begin
                    $error("was_found: expected %0b, got %0b", want.was_found, o_was_found);
                    mismatch_count++;
                end
                if (o_was_created !== want.was_created) begin
                    $error("was_created: expected %0b, got %0b", want.was_created,
                           o_was_created);
                    mismatch_count++;
                end
                if (o_table_full !== want.table_full) begin
                    $error("table_full: expected %0b, got %0b", want.table_full, o_table_full);
                    mismatch_count++;
                end
            end
        end
    end

    // covers the slot sweep after reset and the longest probe chain
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_valid === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_random_mix();
        test_fill_to_capacity();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
